// ===== design/awhd_pkg.sv =====
// Shared types and constants for the alpha-weighted half downsampler.
package awhd_pkg;

   localparam int DEFAULT_MAX_WIDTH = 2048;
   localparam int CMP_W             = 14;
   localparam int SRC_WIDTH_W       = 12;
   localparam int SRC_HEIGHT_W      = 13;
   localparam int ROW_W             = 12;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 13;
   localparam int PIXEL_W           = 32;
   localparam int CHAN_W            = 8;
   localparam int NUM_CHAN          = 3;
   localparam int NUM_W             = 17;
   localparam int SUM_W             = 9;
   localparam int DIV_W             = 16;
   localparam int STEP_W            = 3;

   localparam logic [SRC_WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
   localparam logic [SRC_HEIGHT_W-1:0] HEIGHT_RESET = 13'd2048;
   localparam logic [SRC_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RD_TL = 9'b000000010,
      S_RD_TR = 9'b000000100,
      S_LD_TR = 9'b000001000,
      S_MIX_A = 9'b000010000,
      S_MIX_B = 9'b000100000,
      S_GO_C  = 9'b001000000,
      S_MIX_C = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      MIX_SEL_A = 2'd0,
      MIX_SEL_B = 2'd1,
      MIX_SEL_C = 2'd2
   } mix_sel_type;

   typedef struct packed {
      logic        accept;
      logic        rd_en;
      logic        rd_tr;
      logic        latch_tl;
      logic        latch_tr;
      logic        mix_start;
      mix_sel_type mix_sel;
      logic        cap_m1;
      logic        cap_m2;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic emit_now;
      logic mix_done;
   } status_type;

endpackage

// ===== design/alpha_weighted_half_downsampler_top.sv =====
// Top level of the alpha-weighted 2x2 half-size downsampler.
// Pixels of an even row are accepted from idle and go into the line store;
// pixels of an odd row at an even column are accepted from idle too. The pixel
// that closes a 2x2 block holds off the next pixel while the controller runs
// through the accepting state, two line-store reads on the single read port
// and the operand load, then three pairwise mixes on one shared mixer, whose
// three 8-step restoring dividers run each mix, with a start state before the
// last mix, then the load of the output register. That load waits while the
// previous result is still untaken. The output register lets the next pixel
// in while a result waits to be taken.
module alpha_weighted_half_downsampler_top
   import awhd_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIXEL_W-1:0]     req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIXEL_W-1:0]     rsp_mixed_pixel,
   output logic                   rsp_frame_end,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   awhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   awhd_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pixel       (req_pixel),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_mixed_pixel (rsp_mixed_pixel),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

// ===== design/awhd_mix.sv =====
// Pairwise alpha-weighted mix with a shared iterative divider per channel.
module awhd_mix
   import awhd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PIXEL_W-1:0] p,
   input  logic [PIXEL_W-1:0] q,
   output logic               done,
   output logic [PIXEL_W-1:0] result
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [NUM_W-1:0]    num_ff [NUM_CHAN];
   logic [NUM_W-1:0]    num_in [NUM_CHAN];
   logic [CHAN_W-1:0]   quo_ff [NUM_CHAN];
   logic [CHAN_W-1:0]   quo_in [NUM_CHAN];
   logic [CHAN_W-1:0]   pa, qa;

   assign pa = p[31:24];
   assign qa = q[31:24];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      sum_in  = sum_ff;
      div_in  = div_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         num_in[c] = num_ff[c];
         quo_in[c] = quo_ff[c];
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         sum_in  = {1'b0, pa} + {1'b0, qa};
         div_in  = DIV_W'({sum_in, 7'b0});
         for (int c = 0; c < NUM_CHAN; c++) begin
            num_in[c] = NUM_W'(16'(p[c*CHAN_W +: CHAN_W] * pa))
                      + NUM_W'(16'(q[c*CHAN_W +: CHAN_W] * qa));
            quo_in[c] = '0;
         end
      end else if (busy_ff) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            if (num_ff[c] >= {1'b0, div_ff}) begin
               num_in[c] = num_ff[c] - {1'b0, div_ff};
               quo_in[c] = {quo_ff[c][CHAN_W-2:0], 1'b1};
            end else begin
               quo_in[c] = {quo_ff[c][CHAN_W-2:0], 1'b0};
            end
         end
         div_in  = div_ff >> 1;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CHAN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      sum_ff  <= sum_in;
      div_ff  <= div_in;
      for (int c = 0; c < NUM_CHAN; c++) begin
         num_ff[c] <= num_in[c];
         quo_ff[c] <= quo_in[c];
      end
   end

   assign done   = done_ff;
   assign result = (sum_ff == '0) ? '0 : {sum_ff[8:1], quo_ff[2], quo_ff[1], quo_ff[0]};

endmodule

// ===== design/awhd_datapath.sv =====
// Datapath: counters, line store, operand registers, mixer and output data.
module awhd_datapath
   import awhd_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [PIXEL_W-1:0]     req_pixel,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic [PIXEL_W-1:0]     rsp_mixed_pixel,
   output logic                   rsp_frame_end
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [SRC_WIDTH_W-1:0]  width_ff;
   logic [SRC_HEIGHT_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [PIXEL_W-1:0]      prev_ff, pix_ff, bl_ff, tl_ff, tr_ff, m1_ff, m2_ff;
   logic [PIXEL_W-1:0]      rd_data_ff, out_ff;
   logic                    last_ff, last_in, out_last_ff;
   logic [COL_W-1:0]        tgt_col_ff;
   logic [PIXEL_W-1:0]      row_store [MAX_WIDTH];

   logic [CMP_W-1:0]        w_eff, col_next;
   logic [SRC_HEIGHT_W-1:0] h_eff, row_next;
   logic [COL_W-1:0]        rd_addr;
   logic                    mix_done;
   logic [PIXEL_W-1:0]      mix_p, mix_q, mix_res;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = SRC_HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_LIMIT) begin
         h_eff = HEIGHT_LIMIT;
      end else begin
         h_eff = height_ff;
      end
      col_next = CMP_W'(col_ff) + CMP_W'(1);
      row_next = SRC_HEIGHT_W'(row_ff) + SRC_HEIGHT_W'(1);
      status.emit_now = row_ff[0] && col_ff[0] && (CMP_W'(col_ff) < w_eff)
                      && (SRC_HEIGHT_W'(row_ff) < h_eff);
      status.mix_done = mix_done;
      last_in = (col_next == (w_eff & ~CMP_W'(1)))
             && (row_next == (h_eff & ~SRC_HEIGHT_W'(1)));
      rd_addr = cmd.rd_tr ? tgt_col_ff : (tgt_col_ff - COL_W'(1));
      unique case (cmd.mix_sel)
         MIX_SEL_A: begin
            mix_p = tl_ff;
            mix_q = pix_ff;
         end
         MIX_SEL_B: begin
            mix_p = bl_ff;
            mix_q = tr_ff;
         end
         MIX_SEL_C: begin
            mix_p = m1_ff;
            mix_q = m2_ff;
         end
         default: begin
            mix_p = m1_ff;
            mix_q = m2_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         prev_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_SOURCE_WIDTH:  width_ff  <= csr_wdata[SRC_WIDTH_W-1:0];
               REG_SOURCE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.accept) begin
            prev_ff <= req_pixel;
            if (col_next >= w_eff) begin
               col_ff <= '0;
               row_ff <= (row_next >= h_eff) ? '0 : row_next[ROW_W-1:0];
            end else begin
               col_ff <= col_next[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff     <= req_pixel;
         bl_ff      <= prev_ff;
         tgt_col_ff <= col_ff;
         last_ff    <= last_in;
      end
      if (cmd.accept && !row_ff[0]) begin
         row_store[col_ff] <= req_pixel;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= row_store[rd_addr];
      end
      if (cmd.latch_tl) tl_ff <= rd_data_ff;
      if (cmd.latch_tr) tr_ff <= rd_data_ff;
      if (cmd.cap_m1)   m1_ff <= mix_res;
      if (cmd.cap_m2)   m2_ff <= mix_res;
      if (cmd.out_load) begin
         out_ff      <= mix_res;
         out_last_ff <= last_ff;
      end
   end

   awhd_mix u_mix (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mix_start),
      .p      (mix_p),
      .q      (mix_q),
      .done   (mix_done),
      .result (mix_res)
   );

   assign rsp_mixed_pixel = out_ff;
   assign rsp_frame_end   = out_last_ff;

endmodule

// ===== design/awhd_ctrl.sv =====
// Controller state machine sequencing reads, mixes and the output beat.
module awhd_ctrl
   import awhd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mix_sel = MIX_SEL_A;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.emit_now) state_in = S_RD_TL;
         end
         S_RD_TL: begin
            cmd.rd_en = 1'b1;
            state_in  = S_RD_TR;
         end
         S_RD_TR: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_tr    = 1'b1;
            cmd.latch_tl = 1'b1;
            state_in     = S_LD_TR;
         end
         S_LD_TR: begin
            cmd.latch_tr  = 1'b1;
            cmd.mix_start = 1'b1;
            state_in      = S_MIX_A;
         end
         S_MIX_A: begin
            if (status.mix_done) begin
               cmd.cap_m1    = 1'b1;
               cmd.mix_start = 1'b1;
               cmd.mix_sel   = MIX_SEL_B;
               state_in      = S_MIX_B;
            end
         end
         S_MIX_B: begin
            if (status.mix_done) begin
               cmd.cap_m2 = 1'b1;
               state_in   = S_GO_C;
            end
         end
         S_GO_C: begin
            cmd.mix_start = 1'b1;
            cmd.mix_sel   = MIX_SEL_C;
            state_in      = S_MIX_C;
         end
         S_MIX_C: begin
            if (status.mix_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("output loaded over an untaken beat");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded beat not presented");

   a_done_in_mix: assert property (@(posedge clock) disable iff (reset)
      status.mix_done |-> (state_ff == S_MIX_A || state_ff == S_MIX_B
                           || state_ff == S_MIX_C))
      else $error("mixer finished outside a mix state");

endmodule
